/* rtl/hrht_pkg.sv */
// Package: types, byte codes and state reset value for the HTTP request header tokenizer.
`default_nettype none

package hrht_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    KIND_METHOD       = 3'd0,
    KIND_PATH         = 3'd1,
    KIND_PROTOCOL     = 3'd2,
    KIND_HDR_NAME     = 3'd3,
    KIND_HDR_VALUE    = 3'd4,
    KIND_LINE_END     = 3'd5,
    KIND_HEADERS_DONE = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_new_request;
  } item_t;

  typedef struct packed {
    kind_t      token_kind;
    logic [7:0] token_byte;
    logic       last_of_run;
    logic       headers_done;
  } token_t;

  typedef struct packed {
    logic       after_cr;
    logic       after_line_end;
    logic       in_request_line;
    logic       at_stream_start;
    logic [1:0] request_field_index;
    logic       in_header_value;
    logic       colon_held;
    logic       all_headers_seen;
  } pstate_t;

  localparam pstate_t STATE_RESET = '{
    after_cr:            1'b0,
    after_line_end:      1'b0,
    in_request_line:     1'b1,
    at_stream_start:     1'b1,
    request_field_index: 2'd0,
    in_header_value:     1'b0,
    colon_held:          1'b0,
    all_headers_seen:    1'b0
  };

endpackage

`default_nettype wire

/* rtl/http_request_header_tokenizer.sv */
// Top level: byte-serial HTTP request header tokenizer with a small result queue.
`default_nettype none

// Takes one request byte per cycle while item_stall is low and emits zero, one or two
// tagged tokens for it: request-line fields, header name and value bytes, line-end and
// headers-complete markers. Parser state updates in the cycle a byte is accepted; its
// tokens land in a four-entry result queue and leave one per cycle while token_stall is
// low. Sustained rate is one byte per cycle while each byte yields at most one token and
// the output is not stalled; the single output port drains one token per cycle, so bytes
// that yield two tokens fill the queue faster than it drains, and item_stall rises while
// three or more tokens are pending.
module http_request_header_tokenizer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire hrht_pkg::item_t item,
  input  wire logic            item_valid,
  output logic                 item_stall,
  output hrht_pkg::token_t     token,
  output logic                 token_valid,
  input  wire logic            token_stall
);

  hrht_pkg::pstate_t st;
  hrht_pkg::pstate_t st_next;
  hrht_pkg::token_t  queue [hrht_pkg::QUEUE_DEPTH];
  logic [hrht_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [hrht_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [hrht_pkg::QUEUE_AW:0]   count;
  logic [hrht_pkg::QUEUE_AW:0]   count_next;

  hrht_pkg::kind_t em_kind [2];
  logic [7:0]      em_byte [2];
  logic [1:0]      n_emit;
  hrht_pkg::token_t res0;
  hrht_pkg::token_t res1;
  logic push;
  logic pop;

  always_comb begin
    hrht_pkg::pstate_t cur;
    logic [7:0] c;
    logic [1:0] idx;
    logic       hv;
    logic       ch;
    cur        = item.start_new_request ? hrht_pkg::STATE_RESET : st;
    st_next    = cur;
    c          = item.data_byte;
    n_emit     = 2'd0;
    em_kind[0] = hrht_pkg::KIND_HDR_NAME;
    em_kind[1] = hrht_pkg::KIND_HDR_NAME;
    em_byte[0] = 8'h00;
    em_byte[1] = 8'h00;
    idx        = cur.request_field_index;
    hv         = cur.in_header_value;
    ch         = cur.colon_held;
    if (c == hrht_pkg::CH_CR) begin
      if (cur.colon_held) begin
        em_kind[0] = hrht_pkg::KIND_HDR_NAME;
        em_byte[0] = hrht_pkg::CH_COLON;
        n_emit     = 2'd1;
      end
      st_next.colon_held      = 1'b0;
      st_next.after_cr        = 1'b1;
      st_next.at_stream_start = 1'b0;
    end else if (cur.after_cr && c == hrht_pkg::CH_LF && !cur.after_line_end) begin
      if (!cur.in_request_line) begin
        em_kind[0] = hrht_pkg::KIND_LINE_END;
        n_emit     = 2'd1;
      end
      st_next.after_line_end  = 1'b1;
      st_next.in_request_line = 1'b0;
      st_next.at_stream_start = 1'b0;
    end else begin
      if (cur.after_cr && c == hrht_pkg::CH_LF) begin
        st_next.all_headers_seen = 1'b1;
        em_kind[0] = hrht_pkg::KIND_HEADERS_DONE;
        n_emit     = 2'd1;
      end
      if (cur.in_request_line) begin
        if (cur.at_stream_start || cur.after_line_end) begin
          idx = 2'd0;
        end
        if (c == hrht_pkg::CH_SP) begin
          if (idx != 2'd3) begin
            idx = idx + 2'd1;
          end
        end else if (idx != 2'd3) begin
          em_kind[n_emit[0]] = hrht_pkg::kind_t'({1'b0, idx});
          em_byte[n_emit[0]] = c;
          n_emit             = n_emit + 2'd1;
        end
      end else begin
        if (cur.after_line_end) begin
          hv = 1'b0;
          ch = 1'b0;
        end
        if (hv) begin
          em_kind[n_emit[0]] = hrht_pkg::KIND_HDR_VALUE;
          em_byte[n_emit[0]] = c;
          n_emit             = n_emit + 2'd1;
        end else if (ch && c == hrht_pkg::CH_SP) begin
          ch = 1'b0;
          hv = 1'b1;
        end else begin
          if (ch) begin
            em_kind[n_emit[0]] = hrht_pkg::KIND_HDR_NAME;
            em_byte[n_emit[0]] = hrht_pkg::CH_COLON;
            n_emit             = n_emit + 2'd1;
            ch                 = 1'b0;
          end
          if (c == hrht_pkg::CH_COLON) begin
            ch = 1'b1;
          end else begin
            em_kind[n_emit[0]] = hrht_pkg::KIND_HDR_NAME;
            em_byte[n_emit[0]] = c;
            n_emit             = n_emit + 2'd1;
          end
        end
      end
      st_next.request_field_index = idx;
      st_next.in_header_value     = hv;
      st_next.colon_held          = ch;
      st_next.after_cr            = 1'b0;
      st_next.after_line_end      = 1'b0;
      st_next.at_stream_start     = 1'b0;
    end
  end

  always_comb begin
    res0.token_kind   = em_kind[0];
    res0.token_byte   = em_byte[0];
    res0.last_of_run  = (n_emit == 2'd1);
    res0.headers_done = st_next.all_headers_seen;
    res1.token_kind   = em_kind[1];
    res1.token_byte   = em_byte[1];
    res1.last_of_run  = 1'b1;
    res1.headers_done = st_next.all_headers_seen;
  end

  assign item_stall  = (count >= (hrht_pkg::QUEUE_AW+1)'(hrht_pkg::QUEUE_DEPTH - 1));
  assign push        = item_valid && !item_stall;
  assign token_valid = (count != '0);
  assign pop         = token_valid && !token_stall;
  assign token       = queue[rd_ptr];

  always_comb begin
    count_next = count;
    if (push) begin
      count_next = count_next + {{(hrht_pkg::QUEUE_AW-1){1'b0}}, n_emit};
    end
    if (pop) begin
      count_next = count_next - (hrht_pkg::QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= hrht_pkg::STATE_RESET;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        st     <= st_next;
        wr_ptr <= wr_ptr + hrht_pkg::QUEUE_AW'(n_emit);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + hrht_pkg::QUEUE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && n_emit != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push && n_emit == 2'd2) begin
      queue[wr_ptr + hrht_pkg::QUEUE_AW'(1)] <= res1;
    end
  end

endmodule

`default_nettype wire

/* rtl/hrht_checker.sv */
// Checker: port-level assertions for the HTTP request header tokenizer, with its bind.
`default_nettype none

module hrht_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire hrht_pkg::item_t  item,
  input wire logic             item_valid,
  input wire logic             item_stall,
  input wire hrht_pkg::token_t token,
  input wire logic             token_valid,
  input wire logic             token_stall
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid && $stable(token))
    else $error("token changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !token_valid)
    else $error("token valid right after reset");

  a_done_marker: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.token_kind == hrht_pkg::KIND_HEADERS_DONE |->
      token.headers_done && token.token_byte == 8'h00 && !token.last_of_run)
    else $error("malformed headers-complete marker");

  a_line_end_marker: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.token_kind == hrht_pkg::KIND_LINE_END |->
      token.token_byte == 8'h00 && token.last_of_run)
    else $error("malformed line-end marker");

  a_after_done: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_stall && token.token_kind == hrht_pkg::KIND_HEADERS_DONE |=>
      token_valid && token.token_kind == hrht_pkg::KIND_HDR_NAME &&
      token.token_byte == hrht_pkg::CH_LF && token.last_of_run)
    else $error("headers-complete marker not followed by its LF");

endmodule

bind http_request_header_tokenizer hrht_checker u_hrht_checker (.*);

`default_nettype wire
